// ===== src/simplex_tableau_solver_macros.svh =====
// Assertion shorthands used by the checker in sts_checker.sv.
`ifndef SIMPLEX_TABLEAU_SOLVER_MACROS_SVH
`define SIMPLEX_TABLEAU_SOLVER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define STS_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define STS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sts_pkg.sv =====
package sts_pkg;

  localparam int MAX_ROWS_DEF  = 8;
  localparam int MAX_COLS_DEF  = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int ADDR_W = 4;

  localparam logic [3:0] ROWS_RESET  = 4'd8;
  localparam logic [4:0] COLS_RESET  = 5'd16;
  localparam logic [7:0] LIMIT_RESET = 8'd64;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  localparam logic [1:0] STAT_OPTIMAL   = 2'd0;
  localparam logic [1:0] STAT_UNBOUNDED = 2'd1;
  localparam logic [1:0] STAT_LIMIT     = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [64:0] S65_MAX = 65'sd2147483647;
  localparam logic signed [64:0] S65_MIN = -65'sd2147483648;

  typedef struct packed {
    logic                command;
    logic [3:0]          row_index;
    logic [4:0]          col_index;
    logic signed [31:0]  entry_value;
  } in_word_t;

  typedef struct packed {
    logic [4:0]          var_index;
    logic signed [31:0]  result_value;
    logic [1:0]          solve_status;
    logic                last_item;
  } out_word_t;

  typedef struct packed {
    logic [3:0] rows_in_use;
    logic [4:0] cols_in_use;
    logic [7:0] iteration_limit;
  } cfg_t;

  typedef enum logic {OP_DIV, OP_MULSUB} arith_op_t;

  typedef struct packed {
    logic               start;
    arith_op_t          op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] result;
  } arith_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > S65_MAX) r = S32_MAX;
    else if (v < S65_MIN) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/sts_ram.sv =====
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sts_arith.sv =====
module sts_arith #(
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sts_pkg::arith_req_t req,
  output sts_pkg::arith_rsp_t rsp
);

  import sts_pkg::*;

  // Quotient width: the dividend is the 32-bit magnitude shifted up by the fraction.
  localparam int QW = 32 + FRAC_BITS;
  localparam int SW = $clog2(QW + 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SHIFT, S_SUB, S_DIV, S_DFIN} state_t;

  state_t             state;
  logic signed [31:0] opa, mb, mc, term, result;
  logic signed [63:0] prod;
  logic [31:0]        dvs;
  logic [QW-1:0]      dvd, quo;
  logic [32:0]        rem;
  logic               neg, done;
  logic [SW-1:0]      steps;

  logic [31:0]        a_mag, b_mag;
  logic [32:0]        rem_shift;
  logic               rem_fit;
  logic signed [64:0] q_signed;

  assign a_mag     = req.a[31] ? 32'(-req.a) : 32'(req.a);
  assign b_mag     = req.b[31] ? 32'(-req.b) : 32'(req.b);
  assign rem_shift = {rem[31:0], dvd[QW-1]};
  assign rem_fit   = rem_shift >= {1'b0, dvs};
  assign q_signed  = neg ? -$signed(65'(quo)) : $signed(65'(quo));

  assign rsp.done   = done;
  assign rsp.result = result;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            if (req.op == OP_MULSUB) begin
              opa   <= req.a;
              mb    <= req.b;
              mc    <= req.c;
              state <= S_MUL;
            end else if (req.b == '0) begin
              result <= (req.a >= 0) ? S32_MAX : S32_MIN;
              done   <= 1'b1;
            end else begin
              dvd   <= QW'(a_mag) << FRAC_BITS;
              dvs   <= b_mag;
              rem   <= '0;
              quo   <= '0;
              neg   <= req.a[31] ^ req.b[31];
              steps <= SW'(QW);
              state <= S_DIV;
            end
          end
        end
        S_MUL: begin
          prod  <= mb * mc;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // An arithmetic shift floors the product, as the fixed-point rule asks.
          term  <= sat32(65'(prod >>> FRAC_BITS));
          state <= S_SUB;
        end
        S_SUB: begin
          result <= sat32(65'(opa) - 65'(term));
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_DIV: begin
          rem   <= rem_fit ? rem_shift - {1'b0, dvs} : rem_shift;
          quo   <= {quo[QW-2:0], rem_fit};
          dvd   <= dvd << 1;
          steps <= steps - 1'b1;
          if (steps == SW'(1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          result <= sat32(q_signed);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sts_ctrl.sv =====
module sts_ctrl #(
  parameter int MAX_ROWS  = sts_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = sts_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF,
  localparam int AW = $clog2(MAX_ROWS + 1) + $clog2(MAX_COLS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  sts_pkg::cfg_t       cfg,
  input  logic                item_valid,
  output logic                item_stall,
  input  sts_pkg::in_word_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output sts_pkg::out_word_t  result,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [31:0]         mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [31:0]         mem_rdata,
  output sts_pkg::arith_req_t ar_req,
  input  sts_pkg::arith_rsp_t ar_rsp
);

  import sts_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam logic [RW-1:0] ROW_COST = RW'(MAX_ROWS);
  localparam logic [CW-1:0] COL_RHS  = CW'(MAX_COLS);
  localparam logic [AW-1:0] OBJ_ADDR = {ROW_COST, COL_RHS};
  localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_FC_RD, S_FC_USE, S_DECIDE,
    S_RT_A_RD, S_RT_A_USE, S_RT_B_RD, S_RT_B_USE, S_RT_DIV,
    S_PV_RD, S_PV_USE, S_NR_RD, S_NR_USE, S_NR_DIV,
    S_EL_ROW, S_EL_COL, S_EL_A_RD, S_EL_A_USE, S_EL_B_USE, S_EL_OP, S_PIV_END,
    S_OB_RD, S_OB_USE, S_OB_DEC, S_OB_VAL, S_OB_SEND,
    S_FIN_RD, S_FIN_USE, S_FIN_SEND
  } state_t;

  state_t             state;
  logic [RW-1:0]      i, pr, at, nones, nzeros;
  logic [CW-1:0]      j, pc;
  logic signed [31:0] min_cost, best, col_i, pv, opa, opb;
  logic               found, obj_valid, rd_obj;
  logic [1:0]         status;
  logic [7:0]         pcount;

  logic [RW-1:0]      r_eff, r_last, row_next;
  logic [CW-1:0]      c_eff, c_last, col_next;
  logic signed [31:0] rdata_eff;
  logic               load_ok;

  always_comb begin
    if (cfg.rows_in_use == '0) r_eff = RW'(1);
    else if (32'(cfg.rows_in_use) > MAX_ROWS) r_eff = RW'(MAX_ROWS);
    else r_eff = RW'(cfg.rows_in_use);
    if (cfg.cols_in_use == '0) c_eff = CW'(1);
    else if (32'(cfg.cols_in_use) > MAX_COLS) c_eff = CW'(MAX_COLS);
    else c_eff = CW'(cfg.cols_in_use);
  end

  assign r_last   = r_eff - 1'b1;
  assign c_last   = c_eff - 1'b1;
  // Rows run over the constraint rows and then the cost row; columns over the
  // variable columns and then the right-hand side.
  assign row_next = (i + 1'b1 == r_eff) ? ROW_COST : i + 1'b1;
  assign col_next = (j + 1'b1 == c_eff) ? COL_RHS : j + 1'b1;
  // The objective has a defined reset value although the store has none.
  assign rdata_eff = (rd_obj && !obj_valid) ? '0 : $signed(mem_rdata);
  assign load_ok   = (32'(item.row_index) <= MAX_ROWS) && (32'(item.col_index) <= MAX_COLS);
  assign item_stall = (state != S_IDLE);

  always_comb begin
    mem_raddr = '0;
    case (state)
      S_FC_RD:   mem_raddr = {ROW_COST, j};
      S_RT_A_RD: mem_raddr = {i, pc};
      S_RT_B_RD: mem_raddr = {i, COL_RHS};
      S_PV_RD:   mem_raddr = {pr, pc};
      S_NR_RD:   mem_raddr = {pr, j};
      S_EL_ROW:  mem_raddr = {i, pc};
      S_EL_A_RD: mem_raddr = {i, j};
      S_EL_A_USE: mem_raddr = {pr, j};
      S_OB_RD:   mem_raddr = {i, j};
      S_OB_DEC:  mem_raddr = {at, COL_RHS};
      S_FIN_RD:  mem_raddr = OBJ_ADDR;
      default:   mem_raddr = '0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {i, j};
    mem_wdata = ar_rsp.result;
    case (state)
      S_IDLE: begin
        mem_we    = item_valid && (item.command == CMD_LOAD) && load_ok;
        mem_waddr = {RW'(item.row_index), CW'(item.col_index)};
        mem_wdata = item.entry_value;
      end
      S_NR_DIV: begin
        mem_we    = ar_rsp.done;
        mem_waddr = {pr, j};
      end
      S_EL_OP: mem_we = ar_rsp.done;
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    ar_req.start = 1'b0;
    ar_req.op    = OP_DIV;
    ar_req.a     = rdata_eff;
    ar_req.b     = opb;
    ar_req.c     = rdata_eff;
    case (state)
      S_RT_B_USE: ar_req.start = 1'b1;
      S_NR_USE: begin
        ar_req.start = 1'b1;
        ar_req.b     = pv;
      end
      S_EL_B_USE: begin
        ar_req.start = 1'b1;
        ar_req.op    = OP_MULSUB;
        ar_req.a     = opa;
        ar_req.b     = col_i;
      end
      default: ar_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_obj <= (mem_raddr == OBJ_ADDR);
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      obj_valid    <= 1'b0;
    end else begin
      if (mem_we && mem_waddr == OBJ_ADDR) begin
        obj_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (item_valid && item.command == CMD_SOLVE) begin
            pcount <= '0;
            j      <= '0;
            state  <= S_FC_RD;
          end
        end
        S_FC_RD: state <= S_FC_USE;
        S_FC_USE: begin
          // Strict compare keeps the first of equal minimum costs.
          if (j == '0 || rdata_eff < min_cost) begin
            min_cost <= rdata_eff;
            pc       <= j;
          end
          if (j == c_last) begin
            state <= S_DECIDE;
          end else begin
            j     <= j + 1'b1;
            state <= S_FC_RD;
          end
        end
        S_DECIDE: begin
          if (min_cost >= 0 || pcount >= cfg.iteration_limit) begin
            status <= (min_cost >= 0) ? STAT_OPTIMAL : STAT_LIMIT;
            j      <= '0;
            i      <= '0;
            nones  <= '0;
            nzeros <= '0;
            state  <= S_OB_RD;
          end else begin
            i     <= '0;
            found <= 1'b0;
            state <= S_RT_A_RD;
          end
        end
        S_RT_A_RD: state <= S_RT_A_USE;
        S_RT_A_USE: begin
          if (rdata_eff > 0) begin
            opb   <= rdata_eff;
            state <= S_RT_B_RD;
          end else if (i != r_last) begin
            i     <= i + 1'b1;
            state <= S_RT_A_RD;
          end else if (found) begin
            state <= S_PV_RD;
          end else begin
            status <= STAT_UNBOUNDED;
            j      <= '0;
            i      <= '0;
            nones  <= '0;
            nzeros <= '0;
            state  <= S_OB_RD;
          end
        end
        S_RT_B_RD:  state <= S_RT_B_USE;
        S_RT_B_USE: state <= S_RT_DIV;
        S_RT_DIV: begin
          if (ar_rsp.done) begin
            if (!found || ar_rsp.result < best) begin
              best <= ar_rsp.result;
              pr   <= i;
            end
            found <= 1'b1;
            if (i != r_last) begin
              i     <= i + 1'b1;
              state <= S_RT_A_RD;
            end else begin
              state <= S_PV_RD;
            end
          end
        end
        S_PV_RD: state <= S_PV_USE;
        S_PV_USE: begin
          pv    <= rdata_eff;
          j     <= '0;
          state <= S_NR_RD;
        end
        S_NR_RD:  state <= S_NR_USE;
        S_NR_USE: state <= S_NR_DIV;
        S_NR_DIV: begin
          if (ar_rsp.done) begin
            if (j == COL_RHS) begin
              i     <= '0;
              state <= S_EL_ROW;
            end else begin
              j     <= col_next;
              state <= S_NR_RD;
            end
          end
        end
        S_EL_ROW: begin
          if (i == pr) begin
            i <= row_next;
          end else begin
            state <= S_EL_COL;
          end
        end
        S_EL_COL: begin
          col_i <= rdata_eff;
          j     <= '0;
          state <= S_EL_A_RD;
        end
        S_EL_A_RD: state <= S_EL_A_USE;
        S_EL_A_USE: begin
          opa   <= rdata_eff;
          state <= S_EL_B_USE;
        end
        S_EL_B_USE: state <= S_EL_OP;
        S_EL_OP: begin
          if (ar_rsp.done) begin
            if (j != COL_RHS) begin
              j     <= col_next;
              state <= S_EL_A_RD;
            end else if (i == ROW_COST) begin
              state <= S_PIV_END;
            end else begin
              i     <= row_next;
              state <= S_EL_ROW;
            end
          end
        end
        S_PIV_END: begin
          pcount <= pcount + 1'b1;
          j      <= '0;
          state  <= S_FC_RD;
        end
        S_OB_RD: state <= S_OB_USE;
        S_OB_USE: begin
          if (rdata_eff == '0) begin
            nzeros <= nzeros + 1'b1;
          end else if (rdata_eff == ONE) begin
            nones <= nones + 1'b1;
            at    <= i;
          end
          if (i == r_last) begin
            state <= S_OB_DEC;
          end else begin
            i     <= i + 1'b1;
            state <= S_OB_RD;
          end
        end
        S_OB_DEC: begin
          if (nones == RW'(1) && nzeros == r_last) begin
            state <= S_OB_VAL;
          end else begin
            result       <= '{var_index: 5'(j), result_value: '0,
                              solve_status: status, last_item: 1'b0};
            result_valid <= 1'b1;
            state        <= S_OB_SEND;
          end
        end
        S_OB_VAL: begin
          result       <= '{var_index: 5'(j), result_value: rdata_eff,
                            solve_status: status, last_item: 1'b0};
          result_valid <= 1'b1;
          state        <= S_OB_SEND;
        end
        S_OB_SEND: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            i            <= '0;
            nones        <= '0;
            nzeros       <= '0;
            if (j == c_last) begin
              state <= S_FIN_RD;
            end else begin
              j     <= j + 1'b1;
              state <= S_OB_RD;
            end
          end
        end
        S_FIN_RD: state <= S_FIN_USE;
        S_FIN_USE: begin
          result       <= '{var_index: 5'(MAX_COLS), result_value: rdata_eff,
                            solve_status: status, last_item: 1'b1};
          result_valid <= 1'b1;
          state        <= S_FIN_SEND;
        end
        S_FIN_SEND: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/simplex_tableau_solver.sv =====
// Fixed-point tableau simplex solver with the most-negative-cost entering rule.
// Item channel: item_valid / item_stall / item. A load word writes one tableau
// entry (row MAX_ROWS is the cost row, column MAX_COLS the right-hand side, and
// their crossing the objective) as it is accepted, so loads stream one a cycle.
// A solve word stalls the item channel until its last result word is taken.
// Each pivot scans the cost row, runs the ratio test on every row with a positive
// entering entry, divides the C + 1 entries of the pivot row and updates every
// entry of the other rows, cost row included; the shared divider, one quotient
// bit a cycle, and the single tableau read port bound this work. Reporting then
// sends one word per column, carrying the value of a basic column or zero, and
// a closing word, which carries the maximum and has last_item set. A stalled
// word holds the solver until the receiver takes it.
// Result channel: result_valid / result_stall / result. A stalled word is held
// in the output register unchanged; the solver waits until it is taken.
// Reset empties the pipeline, restores the register defaults and makes the
// objective read as zero until written; tableau entries stay undefined.
// Configuration is an APB-style port with pready always high; write it only
// while the solver is idle, which the block itself does not enforce.
module simplex_tableau_solver #(
  parameter int MAX_ROWS  = sts_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = sts_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  sts_pkg::in_word_t          item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output sts_pkg::out_word_t         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import sts_pkg::*;

  // The tableau memory is addressed by row and column side by side.
  localparam int AW = $clog2(MAX_ROWS + 1) + $clog2(MAX_COLS + 1);

  cfg_t        cfg;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata;
  arith_req_t  ar_req;
  arith_rsp_t  ar_rsp;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  // Configuration registers: the write lands in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_in_use     <= ROWS_RESET;
      cfg.cols_in_use     <= COLS_RESET;
      cfg.iteration_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_ROWS:  cfg.rows_in_use     <= pwdata[3:0];
        REG_COLS:  cfg.cols_in_use     <= pwdata[4:0];
        REG_LIMIT: cfg.iteration_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROWS:  prdata = 32'(cfg.rows_in_use);
      REG_COLS:  prdata = 32'(cfg.cols_in_use);
      REG_LIMIT: prdata = 32'(cfg.iteration_limit);
      default:   prdata = '0;
    endcase
  end

  sts_ctrl #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .ar_req       (ar_req),
    .ar_rsp       (ar_rsp)
  );

  sts_ram #(
    .WIDTH (32),
    .DEPTH (2 ** AW)
  ) u_tableau (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sts_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk (clk),
    .rst (rst),
    .req (ar_req),
    .rsp (ar_rsp)
  );

endmodule

// ===== src/sts_checker.sv =====
`include "simplex_tableau_solver_macros.svh"

module sts_checker #(
  parameter int MAX_COLS = sts_pkg::MAX_COLS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input sts_pkg::out_word_t result
);

  `STS_ASSERT_CLK(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result word changed")
  `STS_ASSERT_RST(a_reset_idle, clk, rst |=> !result_valid && !item_stall, "solver not idle after reset")
  `STS_ASSERT_CLK(a_busy_while_reporting, clk, rst, result_valid |-> item_stall, "item taken while results pending")
  `STS_ASSERT_CLK(a_closing_index, clk, rst, result_valid && result.last_item |-> result.var_index == 5'(MAX_COLS), "closing word has wrong index")

endmodule

bind simplex_tableau_solver sts_checker #(.MAX_COLS(MAX_COLS)) u_sts_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== sim/simplex_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register ports of the simplex solver, predicts
// every result word in fixed point and compares them in order of arrival.
module simplex_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  sts_pkg::in_word_t          item,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  sts_pkg::out_word_t         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending
);
  import sts_pkg::*;

  localparam int NR = MAX_ROWS_DEF;
  localparam int NC = MAX_COLS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int ONE_FX = 1 << FB;

  int coef [NR][NC];
  int rhs_val [NR];
  int cost_val [NC];
  int objective;
  logic [3:0] rows_reg;
  logic [4:0] cols_reg;
  logic [7:0] limit_reg;
  out_word_t expected_words[$];

  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Products are floored, quotients truncated towards zero.
  function automatic int scale_mul(input int a, input int b);
    longint p;
    p = longint'(a) * longint'(b);
    if (p >= 0) return clip32(p >>> FB);
    return clip32(-((-p + (longint'(1) <<< FB) - 1) >>> FB));
  endfunction

  function automatic int scale_div(input int a, input int d);
    if (d == 0) return (a >= 0) ? 32'sh7fffffff : 32'sh80000000;
    return clip32((longint'(a) <<< FB) / longint'(d));
  endfunction

  function automatic int clip_sub(input int a, input int b);
    return clip32(longint'(a) - longint'(b));
  endfunction

  function automatic int rows_eff();
    if (rows_reg < 1) return 1;
    return (rows_reg > NR) ? NR : int'(rows_reg);
  endfunction

  function automatic int cols_eff();
    if (cols_reg < 1) return 1;
    return (cols_reg > NC) ? NC : int'(cols_reg);
  endfunction

  task automatic pivot_on(input int pr, input int pc, input int nr, input int nc);
    int new_row [NC];
    int col_copy [NR];
    int pv;
    int cp;
    pv = coef[pr][pc];
    cp = cost_val[pc];
    for (int i = 0; i < nr; i++) col_copy[i] = coef[i][pc];
    for (int j = 0; j < nc; j++) new_row[j] = scale_div(coef[pr][j], pv);
    rhs_val[pr] = scale_div(rhs_val[pr], pv);
    objective = clip_sub(objective, scale_mul(cp, rhs_val[pr]));
    for (int i = 0; i < nr; i++) begin
      if (i != pr) begin
        for (int j = 0; j < nc; j++)
          coef[i][j] = clip_sub(coef[i][j], scale_mul(col_copy[i], new_row[j]));
        rhs_val[i] = clip_sub(rhs_val[i], scale_mul(col_copy[i], rhs_val[pr]));
      end
    end
    for (int j = 0; j < nc; j++) begin
      cost_val[j] = clip_sub(cost_val[j], scale_mul(cp, new_row[j]));
      coef[pr][j] = new_row[j];
    end
  endtask

  // Runs the pivots of one solve word and queues the column values and the
  // closing word carrying the maximum.
  task automatic solve_tableau();
    int nr;
    int nc;
    int pivots;
    int pc;
    int pr;
    int best;
    int ratio;
    int value;
    int ones;
    int zeros;
    int at_row;
    bit found;
    logic [1:0] status;
    out_word_t w;
    nr = rows_eff();
    nc = cols_eff();
    pivots = 0;
    forever begin
      pc = 0;
      for (int j = 1; j < nc; j++) if (cost_val[j] < cost_val[pc]) pc = j;
      if (cost_val[pc] >= 0) begin
        status = STAT_OPTIMAL;
        break;
      end
      if (pivots >= int'(limit_reg)) begin
        status = STAT_LIMIT;
        break;
      end
      found = 1'b0;
      pr = 0;
      best = 0;
      for (int i = 0; i < nr; i++) begin
        if (coef[i][pc] > 0) begin
          ratio = scale_div(rhs_val[i], coef[i][pc]);
          if (!found || ratio < best) begin
            best = ratio;
            pr = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        status = STAT_UNBOUNDED;
        break;
      end
      pivot_on(pr, pc, nr, nc);
      pivots++;
    end
    for (int j = 0; j < nc; j++) begin
      ones = 0;
      zeros = 0;
      at_row = 0;
      value = 0;
      for (int i = 0; i < nr; i++) begin
        if (coef[i][j] == 0) zeros++;
        else if (coef[i][j] == ONE_FX) begin
          ones++;
          at_row = i;
        end
      end
      if (ones == 1 && zeros == nr - 1) value = rhs_val[at_row];
      w.var_index = j[4:0];
      w.result_value = value;
      w.solve_status = status;
      w.last_item = 1'b0;
      expected_words.insert(expected_words.size(), w);
    end
    w.var_index = NC[4:0];
    w.result_value = objective;
    w.solve_status = status;
    w.last_item = 1'b1;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      limit_reg = LIMIT_RESET;
      objective = 0;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ROWS:  rows_reg = pwdata[3:0];
          REG_COLS:  cols_reg = pwdata[4:0];
          REG_LIMIT: limit_reg = pwdata[7:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected word index %0d value %h",
                           result.var_index, result.result_value));
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (result.var_index !== e.var_index)
            report($sformatf("var_index %0d, want %0d", result.var_index, e.var_index));
          if (result.result_value !== e.result_value)
            report($sformatf("value %h, want %h (var %0d)", result.result_value,
                             e.result_value, e.var_index));
          if (result.solve_status !== e.solve_status)
            report($sformatf("status %0d, want %0d", result.solve_status, e.solve_status));
          if (result.last_item !== e.last_item)
            report($sformatf("last_item %0b, want %0b", result.last_item, e.last_item));
        end
      end
      if (item_valid && !item_stall) begin
        if (item.command == CMD_SOLVE) solve_tableau();
        else if (item.row_index <= NR && item.col_index <= NC) begin
          if (item.row_index == NR) begin
            if (item.col_index == NC) objective = item.entry_value;
            else cost_val[item.col_index] = item.entry_value;
          end else if (item.col_index == NC) rhs_val[item.row_index] = item.entry_value;
          else coef[item.row_index][item.col_index] = item.entry_value;
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== sim/tb_simplex_tableau_solver.sv =====
`timescale 1ns / 1ps

// Stimulus for the simplex solver. Tableaux are loaded word by word and then
// solved; the checker beside the solver predicts and compares every result
// word, and this module only drives the ports and gives the verdict.
module tb_simplex_tableau_solver;
  import sts_pkg::*;

  localparam int NR = MAX_ROWS_DEF;
  localparam int NC = MAX_COLS_DEF;
  localparam int ONE_FX = 1 << FRAC_BITS_DEF;
  // Cycles with no word accepted before the run is declared hung. The limit sits
  // well above the longest stretch without a moving word, which a full-size solve
  // with the longest pivot budget gives.
  localparam int HANG_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_word_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_word_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int pending;

  // Book-keeping of which tableau entries hold a written value, so that a
  // solve never reads an entry that was never loaded.
  bit coef_known [NR][NC];
  bit rhs_known [NR];
  bit cost_known [NC];
  int rows_now;
  int cols_now;
  int words_sent;
  int burst_left;
  bit gaps_on;
  int idle_cycles;

  always #2 clk = ~clk;

  simplex_tableau_solver u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  simplex_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // The receiver switches its stall pattern among no stalls at all, random
  // stalls of varying density, or a fixed rhythm.
  int stall_mode = 0;
  int stall_phase = 0;
  int stall_pct = 0;
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase % 300 == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_pct = $urandom_range(10, 80);
    end
    case (stall_mode)
      0: result_stall = 1'b0;
      1: result_stall = ($urandom_range(0, 99) < stall_pct);
      default: result_stall = (stall_phase % 5) < 2;
    endcase
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one word. The sender works in bursts; between bursts valid drops
  // for a random gap, and in some phases there are no gaps at all.
  task automatic push_word(input in_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        item_valid = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
    item = w;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic load_entry(input int r, input int c, input int v);
    in_word_t w;
    w.command = CMD_LOAD;
    w.row_index = r[3:0];
    w.col_index = c[4:0];
    w.entry_value = v;
    push_word(w);
    if (r <= NR && c <= NC) begin
      words_sent++;
      if (r < NR && c < NC) coef_known[r][c] = 1'b1;
      else if (r < NR) rhs_known[r] = 1'b1;
      else if (c < NC) cost_known[c] = 1'b1;
    end
  endtask

  function automatic int any_entry();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      3: return $urandom_range(0, 8) * ONE_FX;
      4: return -int'($urandom_range(0, 8 * ONE_FX));
      default: return $urandom_range(0, 4 * ONE_FX);
    endcase
  endfunction

  // Loads whatever the next solve will read and has never been written.
  task automatic fill_unknown();
    for (int r = 0; r < rows_now; r++) begin
      for (int c = 0; c < cols_now; c++)
        if (!coef_known[r][c]) load_entry(r, c, $urandom_range(0, 3 * ONE_FX));
      if (!rhs_known[r]) load_entry(r, NC, $urandom_range(0, 10 * ONE_FX));
    end
    for (int c = 0; c < cols_now; c++)
      if (!cost_known[c]) load_entry(NR, c, -int'($urandom_range(0, 4 * ONE_FX)));
  endtask

  task automatic solve_now();
    in_word_t w;
    fill_unknown();
    w.command = CMD_SOLVE;
    w.row_index = 4'($urandom);
    w.col_index = 5'($urandom);
    w.entry_value = $urandom;
    push_word(w);
    words_sent++;
  endtask

  // Registers are only written once every expected word has come back and
  // the solver has had time to settle.
  task automatic write_reg(input logic [1:0] idx, input int value);
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_ROWS) rows_now = (value[3:0] < 1) ? 1 : (value[3:0] > NR ? NR : value[3:0]);
    if (idx == REG_COLS) cols_now = (value[4:0] < 1) ? 1 : (value[4:0] > NC ? NC : value[4:0]);
  endtask

  // A well-formed problem: non-negative right-hand sides, slack columns forming an identity
  // block at the right when columns outnumber rows, and non-positive decision costs.
  task automatic load_problem();
    int first_slack;
    int v;
    first_slack = (cols_now > rows_now) ? cols_now - rows_now : cols_now;
    for (int r = 0; r < rows_now; r++) begin
      for (int c = 0; c < cols_now; c++) begin
        if (c >= first_slack) v = (c - first_slack == r) ? ONE_FX : 0;
        else begin
          v = $urandom_range(0, 4 * ONE_FX);
          if ($urandom_range(0, 9) == 0) v = -v;
          if ($urandom_range(0, 5) == 0) v = 0;
        end
        load_entry(r, c, v);
      end
      load_entry(r, NC, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 20 * ONE_FX));
    end
    for (int c = 0; c < cols_now; c++)
      load_entry(NR, c, (c >= first_slack) ? 0 : -int'($urandom_range(0, 6 * ONE_FX)));
    load_entry(NR, NC, 0);
  endtask

  initial begin
    int shape;
    burst_left = 0;
    gaps_on = 1'b1;
    words_sent = 0;
    rows_now = NR;
    cols_now = NC;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: smallest tableau with extreme values, ignored loads,
    // the objective entry, an unbounded column and a zero ratio.
    write_reg(REG_ROWS, 0);
    write_reg(REG_COLS, 0);
    load_entry(0, 0, 32'sh7fffffff);
    load_entry(0, NC, 32'sh80000000);
    load_entry(NR, 0, 32'sh80000000);
    load_entry(NR, NC, 32'sh7fffffff);
    load_entry(NR + 1, 3, 32'sh12345678);
    load_entry(2, NC + 1, 32'sh12345678);
    load_entry(15, 31, -1);
    solve_now();
    // Unbounded: the entering column has no positive entry.
    load_entry(0, 0, -ONE_FX);
    load_entry(NR, 0, -ONE_FX);
    solve_now();
    // Zero ratio with a pivot value of one least significant bit.
    write_reg(REG_COLS, 2);
    load_entry(0, 0, 1);
    load_entry(0, 1, ONE_FX);
    load_entry(0, NC, 0);
    load_entry(NR, 0, -2 * ONE_FX);
    load_entry(NR, 1, 0);
    load_entry(NR, NC, 0);
    solve_now();
    // A second solve continues from the tableau that the first one left.
    solve_now();
    // Out-of-range register values clamp; a zero pivot budget stops at once.
    write_reg(REG_LIMIT, 0);
    write_reg(REG_ROWS, 15);
    write_reg(REG_COLS, 31);
    load_problem();
    solve_now();
    write_reg(REG_LIMIT, 255);
    load_problem();
    solve_now();

    // Random part: mostly well-formed problems of small size, now and then a
    // full-size one, a long pivot budget on small shapes, and noise loads.
    while (words_sent < 270) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        write_reg(REG_ROWS, NR);
        write_reg(REG_COLS, NC);
        write_reg(REG_LIMIT, $urandom_range(1, 64));
      end else begin
        write_reg(REG_ROWS, $urandom_range(1, 4));
        write_reg(REG_COLS, $urandom_range(1, 8));
        write_reg(REG_LIMIT, (shape == 1) ? 255 : $urandom_range(1, 12));
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 10))
          load_entry($urandom_range(0, 15), $urandom_range(0, 31), any_entry());
      end else begin
        load_problem();
        if ($urandom_range(0, 3) == 0)
          load_entry($urandom_range(0, rows_now - 1), $urandom_range(0, cols_now - 1),
                     any_entry());
      end
      solve_now();
      if ($urandom_range(0, 4) == 0) solve_now();
    end

    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
